[sv/cprm_pkg.sv]
// ---------------------------------------------------------------------------
// cprm_pkg
// Shared constants, codes and types of the copy-on-write page remap engine.
// ---------------------------------------------------------------------------
package cprm_pkg;

    // Geometry
    localparam int PAGE_LOG2     = 12;               // 4 KiB pages
    localparam int PAGE_BYTES    = 1 << PAGE_LOG2;
    localparam int MAP_LOG2      = 16;               // remap table depth
    localparam int MAP_PAGES     = 1 << MAP_LOG2;
    localparam int HUNK_LOG2     = 30;               // 1 GiB hunk files
    localparam int MAX_REQ_PAGES = 63;

    // Field widths
    localparam int W_OP     = 2;
    localparam int W_OFF    = 40;
    localparam int W_LEN    = 18;
    localparam int W_EXP    = 41;
    localparam int W_STATUS = 3;
    localparam int W_KIND   = 3;
    localparam int W_FIDX   = 10;
    localparam int W_DOFF   = 28;
    localparam int W_IN     = 64;                    // 60 bits of fields, padded
    localparam int W_CFG_IX = 2;
    localparam int W_ROOM   = PAGE_LOG2 + 1;
    localparam int W_SLOT   = MAP_LOG2;
    localparam int W_NFREE  = MAP_LOG2 + 1;

    localparam logic [W_LEN-1:0] MAX_LEN   = W_LEN'(MAX_REQ_PAGES * PAGE_BYTES);
    localparam logic [W_EXP-1:0] MAP_SPAN  = W_EXP'(64'(MAP_PAGES) << PAGE_LOG2);
    localparam logic [W_OFF-1:0] HUNK_MASK = W_OFF'((64'(1) << HUNK_LOG2) - 64'(1));

    // Request opcodes
    localparam logic [W_OP-1:0] OP_READ  = 2'd0;
    localparam logic [W_OP-1:0] OP_WRITE = 2'd1;
    localparam logic [W_OP-1:0] OP_DISC  = 2'd2;
    localparam logic [W_OP-1:0] OP_NONE  = 2'd3;

    // Result status codes
    localparam logic [W_STATUS-1:0] ST_OK       = 3'd0;
    localparam logic [W_STATUS-1:0] ST_RANGE    = 3'd1;
    localparam logic [W_STATUS-1:0] ST_RO       = 3'd2;
    localparam logic [W_STATUS-1:0] ST_TOO_LONG = 3'd3;
    localparam logic [W_STATUS-1:0] ST_MAP_FULL = 3'd4;
    localparam logic [W_STATUS-1:0] ST_DISC     = 3'd5;

    // Access kinds
    localparam logic [W_KIND-1:0] KD_ORIG_RD  = 3'd0;
    localparam logic [W_KIND-1:0] KD_DIFF_RD  = 3'd1;
    localparam logic [W_KIND-1:0] KD_DIFF_WR  = 3'd2;
    localparam logic [W_KIND-1:0] KD_FILL_WR  = 3'd3;
    localparam logic [W_KIND-1:0] KD_ORIG_WR  = 3'd4;

    // Configuration register indexes
    localparam logic [W_CFG_IX-1:0] CFG_EXPORT_SIZE = 2'd0;
    localparam logic [W_CFG_IX-1:0] CFG_READ_ONLY   = 2'd1;
    localparam logic [W_CFG_IX-1:0] CFG_COW_ENABLE  = 2'd2;
    localparam logic [W_CFG_IX-1:0] CFG_MULTIFILE   = 2'd3;

    // What the checked request turns into
    typedef enum logic [1:0] {
        CLS_IGNORE,     // unused opcode, no result
        CLS_SINGLE,     // one result (error, zero length, flat access)
        CLS_DISC,       // disconnect result, then clear the map
        CLS_WALK        // page walk through the remap table
    } t_req_class;

    // One result beat, status in the lowest bits
    typedef struct packed {
        logic [W_LEN-1:0]    buffer_offset;
        logic [W_LEN-1:0]    chunk_len;
        logic [W_DOFF-1:0]   diff_offset;
        logic [W_OFF-1:0]    file_offset;
        logic [W_FIDX-1:0]   file_index;
        logic [W_KIND-1:0]   kind;
        logic [W_STATUS-1:0] status;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic take_req;
        logic load_single;
        logic start_walk;
        logic emit_page;
        logic clear_step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_req_class req_class;
        logic       out_free;
        logic       page_end;
        logic       clear_last;
    } t_stat;

endpackage

[sv/cprm_ctrl.sv]
// ---------------------------------------------------------------------------
// cprm_ctrl
// Sequencer: map clear sweep, request intake, check, page walk.
// ---------------------------------------------------------------------------
module cprm_ctrl import cprm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_PAGE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.req_class)
                    CLS_IGNORE: n_state = S_IDLE;
                    CLS_WALK: begin
                        o_cmd.start_walk = 1'b1;
                        n_state          = S_PAGE;
                    end
                    CLS_SINGLE: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_single = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    CLS_DISC: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_single = 1'b1;
                            n_state           = S_CLEAR;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PAGE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_page = 1'b1;
                    if (i_stat.page_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_single || o_cmd.emit_page) |-> i_stat.out_free)
        else $error("result loaded into a busy output register");

    a_disc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_stat.req_class == CLS_DISC && i_stat.out_free)
        |=> (r_state == S_CLEAR))
        else $error("disconnect not followed by a map clear");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAGE && i_stat.out_free && i_stat.page_end)
        |=> (r_state == S_IDLE))
        else $error("page walk ran past its final page");
`endif

endmodule

[sv/cprm_dpath.sv]
// ---------------------------------------------------------------------------
// cprm_dpath
// Config registers, request check, page walk, remap memory, output register.
// ---------------------------------------------------------------------------
module cprm_dpath import cprm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_cfg_wr_en,
    input  logic [W_CFG_IX-1:0] i_cfg_index,
    input  logic [W_EXP-1:0]    i_cfg_data,
    input  logic [W_IN-1:0]     i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out_data,
    output logic                o_out_last
);

    function automatic logic [W_FIDX-1:0] f_hunk_idx(input logic [W_OFF-1:0] addr,
                                                     input logic mf);
        logic [W_OFF-1:0] sh;
        sh = addr >> HUNK_LOG2;
        return mf ? sh[W_FIDX-1:0] : '0;
    endfunction

    function automatic logic [W_OFF-1:0] f_hunk_off(input logic [W_OFF-1:0] addr,
                                                    input logic mf);
        return mf ? (addr & HUNK_MASK) : addr;
    endfunction

    // Configuration
    logic [W_EXP-1:0] r_export_size;
    logic             r_read_only;
    logic             r_cow_en;
    logic             r_multi_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_export_size <= '0;
            r_read_only   <= 1'b0;
            r_cow_en      <= 1'b0;
            r_multi_en    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_EXPORT_SIZE: r_export_size <= i_cfg_data;
                CFG_READ_ONLY:   r_read_only   <= i_cfg_data[0];
                CFG_COW_ENABLE:  r_cow_en      <= i_cfg_data[0];
                CFG_MULTIFILE:   r_multi_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request hold
    logic [W_OP-1:0]  r_op;
    logic [W_OFF-1:0] r_off;
    logic [W_LEN-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_op  <= i_in_data[W_OP-1:0];
            r_off <= i_in_data[W_OP +: W_OFF];
            r_len <= i_in_data[W_OP+W_OFF +: W_LEN];
        end
    end

    // Request check
    logic [W_EXP-1:0] end_sum;
    logic             too_long;
    logic             out_of_range;
    logic             write_ro;
    t_req_class       req_class;
    t_result          sgl;

    always_comb begin
        end_sum      = {1'b0, r_off} + W_EXP'(r_len);
        too_long     = r_len > MAX_LEN;
        out_of_range = (end_sum > r_export_size) ||
                       (r_cow_en && (r_len != '0) && (end_sum > MAP_SPAN));
        write_ro     = (r_op == OP_WRITE) && r_read_only;

        if (r_op == OP_NONE) begin
            req_class = CLS_IGNORE;
        end else if (r_op == OP_DISC) begin
            req_class = CLS_DISC;
        end else if (too_long || out_of_range || write_ro || r_len == '0 || !r_cow_en) begin
            req_class = CLS_SINGLE;
        end else begin
            req_class = CLS_WALK;
        end

        sgl = '0;
        if (r_op == OP_DISC) begin
            sgl.status = ST_DISC;
        end else if (too_long) begin
            sgl.status = ST_TOO_LONG;
        end else if (out_of_range) begin
            sgl.status = ST_RANGE;
        end else if (write_ro) begin
            sgl.status = ST_RO;
        end else begin
            sgl.status = ST_OK;
            sgl.kind   = (r_op == OP_WRITE) ? KD_ORIG_WR : KD_ORIG_RD;
            if (r_len != '0) begin
                sgl.file_index  = f_hunk_idx(r_off, r_multi_en);
                sgl.file_offset = f_hunk_off(r_off, r_multi_en);
                sgl.chunk_len   = r_len;
            end
        end
    end

    // Page walk
    logic [W_OFF-1:0]   r_pos;
    logic [W_LEN-1:0]   r_done;
    logic [W_NFREE-1:0] r_next_free;
    logic [W_SLOT:0]    r_rd_q;      // {valid, slot}
    logic [W_SLOT-1:0]  r_clr_idx;

    logic [PAGE_LOG2-1:0] inpage;
    logic [W_ROOM-1:0]    room;
    logic [W_LEN-1:0]     rest;
    logic [W_LEN-1:0]     chunk;
    logic                 is_last;
    logic                 hit;
    logic                 map_full;
    logic                 page_full;
    logic                 alloc;
    logic [W_SLOT-1:0]    page_idx;
    logic [W_OFF-1:0]     n_pos;
    t_result              pg;

    always_comb begin
        inpage    = r_pos[PAGE_LOG2-1:0];
        room      = W_ROOM'(PAGE_BYTES) - {1'b0, inpage};
        rest      = r_len - r_done;
        is_last   = rest <= W_LEN'(room);
        chunk     = is_last ? rest : W_LEN'(room);
        hit       = r_rd_q[W_SLOT];
        map_full  = r_next_free[W_SLOT];
        page_full = !hit && (r_op == OP_WRITE) && map_full;
        alloc     = i_cmd.emit_page && !hit && (r_op == OP_WRITE) && !map_full;
        page_idx  = r_pos[PAGE_LOG2 +: W_SLOT];
        n_pos     = r_pos + W_OFF'(chunk);

        pg = '0;
        if (page_full) begin
            pg.status = ST_MAP_FULL;
        end else begin
            pg.status        = ST_OK;
            pg.chunk_len     = chunk;
            pg.buffer_offset = r_done;
            if (hit) begin
                pg.kind        = (r_op == OP_WRITE) ? KD_DIFF_WR : KD_DIFF_RD;
                pg.diff_offset = W_DOFF'({r_rd_q[W_SLOT-1:0], inpage});
            end else if (r_op == OP_READ) begin
                pg.kind        = KD_ORIG_RD;
                pg.file_index  = f_hunk_idx(r_pos, r_multi_en);
                pg.file_offset = f_hunk_off(r_pos, r_multi_en);
            end else begin
                pg.kind        = KD_FILL_WR;
                pg.file_index  = f_hunk_idx({r_pos[W_OFF-1:PAGE_LOG2], {PAGE_LOG2{1'b0}}},
                                            r_multi_en);
                pg.file_offset = f_hunk_off({r_pos[W_OFF-1:PAGE_LOG2], {PAGE_LOG2{1'b0}}},
                                            r_multi_en);
                pg.diff_offset = W_DOFF'({r_next_free[W_SLOT-1:0], inpage});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_walk) begin
            r_pos  <= r_off;
            r_done <= '0;
        end else if (i_cmd.emit_page) begin
            r_pos  <= n_pos;
            r_done <= r_done + chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.load_single && req_class == CLS_DISC) begin
                r_next_free <= '0;
                r_clr_idx   <= '0;
            end else begin
                if (alloc) begin
                    r_next_free <= r_next_free + W_NFREE'(1);
                end
                if (i_cmd.clear_step) begin
                    r_clr_idx <= r_clr_idx + W_SLOT'(1);
                end
            end
        end
    end

    // Remap memory: one write port (sweep or allocation), one registered read
    logic [W_SLOT:0]   r_map_mem [MAP_PAGES];
    logic              mem_we;
    logic [W_SLOT-1:0] mem_waddr;
    logic [W_SLOT:0]   mem_wdata;
    logic              mem_re;
    logic [W_SLOT-1:0] mem_raddr;

    always_comb begin
        mem_we    = i_cmd.clear_step || alloc;
        mem_waddr = i_cmd.clear_step ? r_clr_idx : page_idx;
        mem_wdata = i_cmd.clear_step ? '0 : {1'b1, r_next_free[W_SLOT-1:0]};
        mem_re    = i_cmd.start_walk || (i_cmd.emit_page && !is_last && !page_full);
        mem_raddr = i_cmd.start_walk ? r_off[PAGE_LOG2 +: W_SLOT]
                                     : n_pos[PAGE_LOG2 +: W_SLOT];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q <= r_map_mem[mem_raddr];
        end
    end

    // Output register
    logic    r_out_valid;
    t_result r_out;
    logic    r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.emit_page) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_out      <= sgl;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_page) begin
            r_out      <= pg;
            r_out_last <= is_last || page_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_out_last  = r_out_last;

    assign o_stat.req_class  = req_class;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.page_end   = is_last || page_full;
    assign o_stat.clear_last = r_clr_idx == '1;

`ifndef NO_ASSERTIONS
    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> !r_next_free[W_SLOT])
        else $error("slot allocated from a full map");

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_page |-> (r_done < r_len))
        else $error("page emitted past the end of the request");

    a_disc_resets_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_single && req_class == CLS_DISC) |=> (r_next_free == '0))
        else $error("disconnect left the free slot counter set");
`endif

endmodule

[sv/cow_page_remap_engine.sv]
// ---------------------------------------------------------------------------
// cow_page_remap_engine
// Turns block requests into original-file and diff-store accesses through a
// copy-on-write page remap table.
// ---------------------------------------------------------------------------
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+---------------------------
//  request  | s_axis_tvalid/tready/tdata           | op, offset, length
//  result   | m_axis_tvalid/tready/tdata/tlast     | status .. buffer_offset, last
//  config   | i_cfg_wr_en/index/data               | export_size, read_only,
//           |                                      | cow_enable, multifile_enable
//
//  One request at a time, accepted while idle and then checked. A
//  single-result request is done once its result is loaded. Unless the
//  result side stalls, a copy-on-write request then spends one cycle per
//  page touched (up to 64), bounded by the single read port of the remap
//  memory: each page's lookup is issued while the previous page's result
//  is loaded. After reset and after every disconnect, the remap valid bits
//  are swept clear, one entry per cycle, and no request is taken meanwhile.
//  A stalled result beat holds the walk; the output register frees the
//  request side as soon as the last beat of a request is loaded.
// ---------------------------------------------------------------------------
module cow_page_remap_engine import cprm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request: [1:0] op, [41:2] offset, [59:42] length, [63:60] zero
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [W_IN-1:0]     s_axis_tdata,
    // result: [2:0] status, [5:3] kind, [15:6] file_index, [55:16] file_offset,
    //         [83:56] diff_offset, [101:84] chunk_len, [119:102] buffer_offset
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [119:0]        m_axis_tdata,
    output logic                m_axis_tlast,
    // configuration write port
    input  logic                i_cfg_wr_en,
    input  logic [W_CFG_IX-1:0] i_cfg_index,
    input  logic [W_EXP-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_stat   stat;
    t_result out_data;

    // Sequencer: owns intake, check decision, walk pacing and the clear sweep
    cprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: config, range checks, remap memory, result register
    cprm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data),
        .o_out_last  (m_axis_tlast)
    );

    // Take a request only while the sequencer sits idle
    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = out_data;

endmodule
